// ----- src/ohkt_pkg.sv -----
// ----------------------------------------------------------------------------
// ohkt_pkg
// shared constants, codes and types of the ordered held-key tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ohkt_pkg;

    localparam int MAX_HELD_KEYS = 16;
    localparam int IDX_W         = (MAX_HELD_KEYS > 1) ? $clog2(MAX_HELD_KEYS) : 1;
    localparam int CNT_W         = $clog2(MAX_HELD_KEYS + 1);
    localparam int KEY_W         = 8;
    localparam int FUNC_W        = 2;
    localparam int POS_W         = 5;
    localparam int COUNT_W       = 5;

    localparam logic [POS_W-1:0] POS_NONE = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PRESS   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_QUERY   = 2'd2,
        FUNC_COMBO   = 2'd3
    } func_t;

    typedef struct packed {
        logic             append_en;
        logic [IDX_W-1:0] append_idx;
        logic             shift_en;
        logic [IDX_W-1:0] rd_idx;
    } list_cmd_t;

endpackage

`default_nettype wire

// ----- src/ohkt_list.sv -----
// ----------------------------------------------------------------------------
// ohkt_list
// held key storage with one read port, append and close-gap writes, and the
// shared key compare unit
// ----------------------------------------------------------------------------
`default_nettype none

module ohkt_list (
    input  wire logic                   clk,
    input  wire ohkt_pkg::list_cmd_t    cmd,
    input  wire logic [ohkt_pkg::KEY_W-1:0] key,
    output logic                        hit
);
    import ohkt_pkg::*;

    logic [KEY_W-1:0] entry_reg [MAX_HELD_KEYS];
    logic [KEY_W-1:0] rd_data;
    logic [IDX_W-1:0] shift_dst;

    assign rd_data   = entry_reg[cmd.rd_idx];
    assign shift_dst = cmd.rd_idx - IDX_W'(1);
    assign hit       = (rd_data == key);

    always_ff @(posedge clk)
    begin
        if (cmd.append_en)
        begin
            entry_reg[cmd.append_idx] <= key;
        end
        else if (cmd.shift_en)
        begin
            entry_reg[shift_dst] <= rd_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/ordered_held_key_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_held_key_tracker_unit
// held key list in press order with query and hotkey combo matching
// ----------------------------------------------------------------------------
// query, press and release search the list of held keys (up to 16) in press order;
//   a release then closes the gap and a combo element searches the list once more
// one word at a time; the single key compare scans one list entry per cycle
// a new word is taken once the previous result is loaded into the output stage
// reset clears the list length and combo state; list entries are not cleared
`default_nettype none

module ordered_held_key_tracker_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ohkt_pkg::FUNC_W-1:0]   func,
    input  wire logic [ohkt_pkg::KEY_W-1:0]    key_code,
    input  wire logic                          ordered_mode,
    input  wire logic                          combo_last,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               is_held,
    output logic signed [ohkt_pkg::POS_W-1:0]  position,
    output logic [ohkt_pkg::COUNT_W-1:0]       held_count,
    output logic                               combo_match,
    output logic                               press_dropped
);
    import ohkt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_APPLY,
        S_SHIFT,
        S_FIND,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               ord_reg, ord_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   cnext_reg, cnext_next;
    logic               cfail_reg, cfail_next;
    logic [CNT_W-1:0]   scan_reg, scan_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   fpos_reg, fpos_next;
    logic               res_held_reg, res_held_next;
    logic [IDX_W-1:0]   res_pos_reg, res_pos_next;
    logic               res_match_reg, res_match_next;
    logic               res_drop_reg, res_drop_next;

    logic               out_valid_reg, out_valid_next;
    logic               is_held_reg, is_held_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [COUNT_W-1:0] held_count_reg, held_count_next;
    logic               combo_match_reg, combo_match_next;
    logic               press_dropped_reg, press_dropped_next;

    list_cmd_t          cmd;
    logic               hit;
    logic               in_range;
    logic               fail_now;

    ohkt_list u_list (
        .clk (clk),
        .cmd (cmd),
        .key (key_reg),
        .hit (hit)
    );

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign is_held       = is_held_reg;
    assign position      = position_reg;
    assign held_count    = held_count_reg;
    assign combo_match   = combo_match_reg;
    assign press_dropped = press_dropped_reg;

    assign in_range = (scan_reg < len_reg);
    assign fail_now = cfail_reg || !found_reg;

    always_comb
    begin
        state_next         = state_reg;
        func_next          = func_reg;
        key_next           = key_reg;
        ord_next           = ord_reg;
        last_next          = last_reg;
        len_next           = len_reg;
        cnext_next         = cnext_reg;
        cfail_next         = cfail_reg;
        scan_next          = scan_reg;
        found_next         = found_reg;
        fpos_next          = fpos_reg;
        res_held_next      = res_held_reg;
        res_pos_next       = res_pos_reg;
        res_match_next     = res_match_reg;
        res_drop_next      = res_drop_reg;
        out_valid_next     = out_valid_reg && out_stall;
        is_held_next       = is_held_reg;
        position_next      = position_reg;
        held_count_next    = held_count_reg;
        combo_match_next   = combo_match_reg;
        press_dropped_next = press_dropped_reg;

        cmd.append_en  = 1'b0;
        cmd.append_idx = len_reg[IDX_W-1:0];
        cmd.shift_en   = 1'b0;
        cmd.rd_idx     = scan_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next      = func_t'(func);
                    key_next       = key_code;
                    ord_next       = ordered_mode;
                    last_next      = combo_last;
                    found_next     = 1'b0;
                    res_match_next = 1'b0;
                    res_drop_next  = 1'b0;
                    scan_next      = '0;
                    if (func_t'(func) == FUNC_COMBO && ordered_mode)
                    begin
                        scan_next = cnext_reg;
                    end
                    if (func_t'(func) == FUNC_COMBO && cfail_reg)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_CHECK:
            begin
                if (in_range)
                begin
                    if (hit)
                    begin
                        found_next = 1'b1;
                        fpos_next  = scan_reg[IDX_W-1:0];
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        scan_next = scan_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = S_APPLY;
                end
            end

            S_APPLY:
            begin
                unique case (func_reg)
                    FUNC_PRESS:
                    begin
                        state_next = S_DONE;
                        if (found_reg)
                        begin
                            res_held_next = 1'b1;
                            res_pos_next  = fpos_reg;
                        end
                        else if (len_reg < CNT_W'(MAX_HELD_KEYS))
                        begin
                            cmd.append_en = 1'b1;
                            res_held_next = 1'b1;
                            res_pos_next  = len_reg[IDX_W-1:0];
                            len_next      = len_reg + CNT_W'(1);
                        end
                        else
                        begin
                            res_held_next = 1'b0;
                            res_drop_next = 1'b1;
                        end
                    end

                    FUNC_RELEASE:
                    begin
                        res_held_next = 1'b0;
                        if (found_reg)
                        begin
                            scan_next  = CNT_W'(fpos_reg) + CNT_W'(1);
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end

                    FUNC_QUERY:
                    begin
                        res_held_next = found_reg;
                        res_pos_next  = fpos_reg;
                        state_next    = S_DONE;
                    end

                    FUNC_COMBO:
                    begin
                        if (!cfail_reg && ord_reg && found_reg)
                        begin
                            cnext_next = CNT_W'(fpos_reg) + CNT_W'(1);
                        end
                        if (last_reg)
                        begin
                            res_match_next = !fail_now;
                            cnext_next     = '0;
                            cfail_next     = 1'b0;
                        end
                        else
                        begin
                            cfail_next = fail_now;
                        end
                        scan_next  = '0;
                        state_next = S_FIND;
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SHIFT:
            begin
                if (in_range)
                begin
                    cmd.shift_en = 1'b1;
                    scan_next    = scan_reg + CNT_W'(1);
                end
                else
                begin
                    len_next   = len_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_FIND:
            begin
                if (in_range)
                begin
                    if (hit)
                    begin
                        res_held_next = 1'b1;
                        res_pos_next  = scan_reg[IDX_W-1:0];
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        scan_next = scan_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    res_held_next = 1'b0;
                    state_next    = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    is_held_next       = res_held_reg;
                    position_next      = res_held_reg ? POS_W'(res_pos_reg) : POS_NONE;
                    held_count_next    = COUNT_W'(len_reg);
                    combo_match_next   = res_match_reg;
                    press_dropped_next = res_drop_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cnext_reg     <= '0;
            cfail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cnext_reg     <= cnext_next;
            cfail_reg     <= cfail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg          <= func_next;
        key_reg           <= key_next;
        ord_reg           <= ord_next;
        last_reg          <= last_next;
        scan_reg          <= scan_next;
        found_reg         <= found_next;
        fpos_reg          <= fpos_next;
        res_held_reg      <= res_held_next;
        res_pos_reg       <= res_pos_next;
        res_match_reg     <= res_match_next;
        res_drop_reg      <= res_drop_next;
        is_held_reg       <= is_held_next;
        position_reg      <= position_next;
        held_count_reg    <= held_count_next;
        combo_match_reg   <= combo_match_next;
        press_dropped_reg <= press_dropped_next;
    end

endmodule

`default_nettype wire

// ----- src/ohkt_checker.sv -----
// ----------------------------------------------------------------------------
// ohkt_checker
// port-level checks of the held key tracker, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ohkt_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          is_held,
    input  wire logic signed [ohkt_pkg::POS_W-1:0] position,
    input  wire logic [ohkt_pkg::COUNT_W-1:0]  held_count,
    input  wire logic                          press_dropped
);
    import ohkt_pkg::*;

    // a key that is not held reports no position
    a_not_held_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_held |-> position == POS_NONE)
        else $error("not-held result with a position");

    // a dropped press never reports the key as held
    a_drop_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_dropped |-> !is_held)
        else $error("dropped press reported as held");

    // a held key sits inside the list
    a_pos_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_held |-> $unsigned(position) < held_count)
        else $error("held position beyond list length");

    // one word at a time: busy right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a word is in progress");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) && $stable(held_count))
        else $error("stalled result changed");

endmodule

bind ordered_held_key_tracker_unit ohkt_checker u_ohkt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_held       (is_held),
    .position      (position),
    .held_count    (held_count),
    .press_dropped (press_dropped)
);

`default_nettype wire
